### design/vau_pkg.sv
// Shared constants, state type and arctangent table of the vector angle unit.
package vau_pkg;

  localparam int CROSS_W = 32;
  localparam int DOT_OUT_W = 33;
  localparam int LEN_W = 16;
  localparam int ANGLE_W = 15;
  localparam int ROOT_W = 24;
  localparam int Q_W = 17;
  localparam int CORDIC_STEPS = 26;
  localparam int DIV_STEPS = 18;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_LA,
    ST_PROD,
    ST_DSET,
    ST_DIV,
    ST_QQ,
    ST_SQGO,
    ST_SQ,
    ST_ROT,
    ST_OUT
  } back_state_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### design/vau_front.sv
// Front end: accepts vector pairs, forms products, cross, dot and squared lengths.
module vau_front import vau_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_z,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [3*CROSS_W+6*COMPONENT_WIDTH:0] push_data
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;

  logic a_valid_r, b_valid_r;
  logic a_adv, b_adv;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [PW-1:0] p_aybz_r, p_azby_r, p_azbx_r, p_axbz_r, p_axby_r, p_aybx_r;
  logic signed [PW-1:0] p_axbx_r, p_ayby_r, p_azbz_r;
  logic signed [PW-1:0] p_axax_r, p_ayay_r, p_azaz_r, p_bxbx_r, p_byby_r, p_bzbz_r;
  logic signed [DW-1:0] cx_w, cy_w, cz_w, dot_w;
  logic [PW-1:0] sa_w, sb_w;

  assign b_adv = !b_valid_r || push_ready;
  assign a_adv = !a_valid_r || b_adv;
  assign in_ready = a_adv;
  assign push_valid = b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_adv) a_valid_r <= in_valid;
      if (b_adv) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      ax_r <= in_first_x;
      ay_r <= in_first_y;
      az_r <= in_first_z;
      bx_r <= in_second_x;
      by_r <= in_second_y;
      bz_r <= in_second_z;
    end
    if (b_adv && a_valid_r) begin
      p_aybz_r <= ay_r * bz_r;
      p_azby_r <= az_r * by_r;
      p_azbx_r <= az_r * bx_r;
      p_axbz_r <= ax_r * bz_r;
      p_axby_r <= ax_r * by_r;
      p_aybx_r <= ay_r * bx_r;
      p_axbx_r <= ax_r * bx_r;
      p_ayby_r <= ay_r * by_r;
      p_azbz_r <= az_r * bz_r;
      p_axax_r <= ax_r * ax_r;
      p_ayay_r <= ay_r * ay_r;
      p_azaz_r <= az_r * az_r;
      p_bxbx_r <= bx_r * bx_r;
      p_byby_r <= by_r * by_r;
      p_bzbz_r <= bz_r * bz_r;
    end
  end

  assign cx_w = DW'(p_aybz_r) - DW'(p_azby_r);
  assign cy_w = DW'(p_azbx_r) - DW'(p_axbz_r);
  assign cz_w = DW'(p_axby_r) - DW'(p_aybx_r);
  assign dot_w = DW'(p_axbx_r) + DW'(p_ayby_r) + DW'(p_azbz_r);
  assign sa_w = $unsigned(p_axax_r) + $unsigned(p_ayay_r) + $unsigned(p_azaz_r);
  assign sb_w = $unsigned(p_bxbx_r) + $unsigned(p_byby_r) + $unsigned(p_bzbz_r);

  assign push_data = {CROSS_W'(cx_w), CROSS_W'(cy_w), CROSS_W'(cz_w), dot_w, sa_w, sb_w};

endmodule

### design/vau_queue.sv
// Two-entry word queue between front and back ends.
module vau_queue import vau_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

endmodule

### design/vau_sqrt.sv
// Bit-serial floor square root, one root bit per cycle.
module vau_sqrt import vau_pkg::*; #(
  parameter int RAD_W = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int HW = RAD_W / 2;
  localparam int CNT_W = $clog2(HW + 1);

  logic [RAD_W-1:0] rad_r;
  logic [HW+2:0]    rem_r;
  logic [HW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [HW+2:0]    rem_sh, trial;
  logic             ge;

  assign rem_sh = {rem_r[HW:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge = (rem_sh >= trial);
  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(HW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      root_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[HW-2:0], ge};
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule

### design/vau_back.sv
// Back end: lengths, cosine division, CORDIC arccosine and result register.
module vau_back import vau_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_FRACTION_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [3*CROSS_W+6*COMPONENT_WIDTH:0] pop_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [CROSS_W-1:0]         out_cross_x,
  output logic signed [CROSS_W-1:0]         out_cross_y,
  output logic signed [CROSS_W-1:0]         out_cross_z,
  output logic signed [DOT_OUT_W-1:0]       out_dot_value,
  output logic [LEN_W-1:0]                  out_first_length,
  output logic [LEN_W-1:0]                  out_second_length,
  output logic [ANGLE_W-1:0]                out_angle,
  output logic                              out_degenerate
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;
  localparam int RW = (PW + 16 > 34) ? PW + 16 : 34;
  localparam int HW = RW / 2;
  localparam int SH = (CW > 16) ? 2 * (CW - 16) : 0;
  localparam bit WIDE = (CW > 16);
  localparam logic [33:0] ROUND_ADD = 34'(1) << (29 - ANGLE_FRACTION_BITS);

  back_state_t state_r, state_nxt;

  logic [CROSS_W-1:0] cx_r, cy_r, cz_r;
  logic signed [DW-1:0] dot_r;
  logic [PW-1:0] sa_r, sb_r;
  logic [LEN_W-1:0] len_a_r, len_b_r;
  logic [ROOT_W-1:0] la_r, lb_r;
  logic [2*ROOT_W-1:0] prod_r;
  logic [65:0] rem_r, dv_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [Q_W-1:0] q_r, qsat;
  logic [33:0] qq_r, qsat_w;
  logic [4:0] step_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic out_valid_r;

  logic sq_start_a, sq_start_b, sq_done_a, sq_done_b;
  logic [RW-1:0] rad_a, rad_b;
  logic [HW-1:0] root_a, root_b;

  logic dot_neg;
  logic [DW-1:0] abs_dot;
  logic [31:0] d_val;
  logic [PW-1:0] a_red, b_red, a_red1, b_red1;
  logic div_ge;
  logic signed [33:0] xs, ys, at_val, zc;
  logic [33:0] z_round;
  logic [Q_W-1:0] sq_val;
  logic cneg, degen, out_fire;

  vau_sqrt #(.RAD_W(RW)) u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .start(sq_start_a), .radicand(rad_a),
    .done(sq_done_a), .root(root_a)
  );

  vau_sqrt #(.RAD_W(RW)) u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .start(sq_start_b), .radicand(rad_b),
    .done(sq_done_b), .root(root_b)
  );

  assign dot_neg = dot_r[DW-1];
  assign abs_dot = dot_neg ? $unsigned(-dot_r) : $unsigned(dot_r);
  assign d_val = 32'(abs_dot >> SH);
  assign a_red = sa_r >> SH;
  assign b_red = sb_r >> SH;
  assign a_red1 = (a_red == '0) ? PW'(1) : a_red;
  assign b_red1 = (b_red == '0) ? PW'(1) : b_red;
  assign div_ge = (rem_r >= dv_r);
  assign qsat = (quo_r > DIV_STEPS'(ONE_Q16)) ? ONE_Q16 : Q_W'(quo_r);
  assign qsat_w = 34'(qsat);
  assign sq_val = Q_W'(root_a);
  assign cneg = dot_neg && (q_r != '0);
  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign at_val = signed'(34'(atan_q30(step_r)));
  assign zc = z_r[33] ? 34'sd0 : ((z_r > PI_Q30) ? PI_Q30 : z_r);
  assign z_round = $unsigned(zc) + ROUND_ADD;
  assign degen = (sa_r == '0) || (sb_r == '0);
  assign out_fire = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_LEN;
      ST_LEN:  if (sq_done_a) state_nxt = WIDE ? ST_LA : ST_PROD;
      ST_LA:   if (sq_done_a) state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_DSET;
      ST_DSET: state_nxt = ST_DIV;
      ST_DIV:  if (step_r == 5'(DIV_STEPS - 1)) state_nxt = ST_QQ;
      ST_QQ:   state_nxt = ST_SQGO;
      ST_SQGO: state_nxt = ST_SQ;
      ST_SQ:   if (sq_done_a) state_nxt = ST_ROT;
      ST_ROT:  if (step_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    sq_start_a = 1'b0;
    sq_start_b = 1'b0;
    rad_a = RW'({pop_data[2*PW-1:PW], 16'h0});
    rad_b = RW'({pop_data[PW-1:0], 16'h0});
    case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        sq_start_a = pop_valid;
        sq_start_b = pop_valid;
      end
      ST_LEN: begin
        rad_a = RW'({a_red1, 16'h0});
        rad_b = RW'({b_red1, 16'h0});
        sq_start_a = sq_done_a && WIDE;
        sq_start_b = sq_done_a && WIDE;
      end
      ST_SQGO: begin
        rad_a = RW'(ONE_Q32 - qq_r);
        sq_start_a = 1'b1;
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cx_r <= pop_data[2*PW+DW+3*CROSS_W-1 -: CROSS_W];
          cy_r <= pop_data[2*PW+DW+2*CROSS_W-1 -: CROSS_W];
          cz_r <= pop_data[2*PW+DW+CROSS_W-1 -: CROSS_W];
          dot_r <= signed'(pop_data[2*PW+DW-1 -: DW]);
          sa_r <= pop_data[2*PW-1:PW];
          sb_r <= pop_data[PW-1:0];
        end
      end
      ST_LEN: begin
        if (sq_done_a) begin
          len_a_r <= LEN_W'(root_a[HW-1:8]);
          len_b_r <= LEN_W'(root_b[HW-1:8]);
          la_r <= (sa_r == '0) ? ROOT_W'(256) : ROOT_W'(root_a);
          lb_r <= (sb_r == '0) ? ROOT_W'(256) : ROOT_W'(root_b);
        end
      end
      ST_LA: begin
        if (sq_done_a) begin
          la_r <= ROOT_W'(root_a);
          lb_r <= ROOT_W'(root_b);
        end
      end
      ST_PROD: prod_r <= la_r * lb_r;
      ST_DSET: begin
        dv_r <= 66'(prod_r) << (DIV_STEPS - 1);
        rem_r <= {2'b00, d_val, 32'h0};
        quo_r <= '0;
        step_r <= '0;
      end
      ST_DIV: begin
        if (div_ge) rem_r <= rem_r - dv_r;
        quo_r <= {quo_r[DIV_STEPS-2:0], div_ge};
        dv_r <= dv_r >> 1;
        step_r <= step_r + 5'd1;
      end
      ST_QQ: begin
        q_r <= qsat;
        qq_r <= qsat_w * qsat_w;
      end
      ST_SQ: begin
        if (sq_done_a) begin
          step_r <= '0;
          if (cneg) begin
            x_r <= signed'(34'(sq_val) << 12);
            y_r <= signed'(34'(q_r) << 12);
            z_r <= HALF_PI_Q30;
          end else begin
            x_r <= signed'(34'(q_r) << 12);
            y_r <= signed'(34'(sq_val) << 12);
            z_r <= 34'sd0;
          end
        end
      end
      ST_ROT: begin
        if (!y_r[33]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at_val;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at_val;
        end
        step_r <= step_r + 5'd1;
      end
      ST_OUT: begin
        if (out_fire) begin
          out_cross_x <= signed'(cx_r);
          out_cross_y <= signed'(cy_r);
          out_cross_z <= signed'(cz_r);
          out_dot_value <= DOT_OUT_W'(dot_r);
          out_first_length <= len_a_r;
          out_second_length <= len_b_r;
          out_angle <= degen ? '0 : ANGLE_W'(z_round >> (30 - ANGLE_FRACTION_BITS));
          out_degenerate <= degen;
        end
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### design/vector_angle_unit.sv
// Top level of the vector angle unit.
// Takes pairs of 3D vectors and returns cross product, dot product, both
// lengths and the angle between them (Q2.13 radians by default). The back
// end works on one pair at a time with the bit-serial square root units
// (one root bit a cycle; a second root pass when COMPONENT_WIDTH > 16), the
// 18-step restoring divider and the 26-step CORDIC. The front end takes a
// new pair every cycle while the two-entry queue has room, and a finished
// result waits in the output register while the next pair is worked on.
module vector_angle_unit import vau_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_FRACTION_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [CROSS_W-1:0]         out_cross_x,
  output logic signed [CROSS_W-1:0]         out_cross_y,
  output logic signed [CROSS_W-1:0]         out_cross_z,
  output logic signed [DOT_OUT_W-1:0]       out_dot_value,
  output logic [LEN_W-1:0]                  out_first_length,
  output logic [LEN_W-1:0]                  out_second_length,
  output logic [ANGLE_W-1:0]                out_angle,
  output logic                              out_degenerate
);

  localparam int EW = 3 * CROSS_W + 6 * COMPONENT_WIDTH + 1;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  vau_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  vau_queue #(.WIDTH(EW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  vau_back #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y), .out_cross_z(out_cross_z),
    .out_dot_value(out_dot_value),
    .out_first_length(out_first_length), .out_second_length(out_second_length),
    .out_angle(out_angle), .out_degenerate(out_degenerate)
  );

endmodule
